// ----- rtl/jsu_pkg.sv -----
// Package for the JSON string unescape unit: phase codes, error codes,
// character constants, decoder state and result structs, hex digit decode.
// Used by jsu_decode and json_string_unescape_unit.
package jsu_pkg;

    localparam int DATA_W = 8;
    localparam int ERR_W  = 3;
    localparam int ACC_W  = 16;
    localparam int HEXC_W = 2;

    // Decoder phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_STR  = 4'b0010,
        PH_ESC  = 4'b0100,
        PH_HEX  = 4'b1000
    } phase_t;

    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NO_QUOTE  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_UNT_ESC   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_UNI   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BAD_ESC   = 3'd4;
    localparam logic [ERR_W-1:0] ERR_UNT_STR   = 3'd5;

    localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
    localparam logic [DATA_W-1:0] CH_TAB   = 8'h09;
    localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
    localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
    localparam logic [DATA_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [DATA_W-1:0] CH_BSL   = 8'h5C;
    localparam logic [DATA_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [DATA_W-1:0] CH_QMARK = 8'h3F;
    localparam logic [DATA_W-1:0] CH_LC_B  = 8'h62;
    localparam logic [DATA_W-1:0] CH_LC_F  = 8'h66;
    localparam logic [DATA_W-1:0] CH_LC_N  = 8'h6E;
    localparam logic [DATA_W-1:0] CH_LC_R  = 8'h72;
    localparam logic [DATA_W-1:0] CH_LC_T  = 8'h74;
    localparam logic [DATA_W-1:0] CH_LC_U  = 8'h75;
    localparam logic [DATA_W-1:0] CH_BS    = 8'h08;
    localparam logic [DATA_W-1:0] CH_FF    = 8'h0C;

    localparam logic [ACC_W-1:0] ASCII_LIMIT = 16'd128;

    typedef struct packed {
        phase_t            phase;
        logic [HEXC_W-1:0] hex_cnt;
        logic [ACC_W-1:0]  acc;
    } jsu_state_t;

    typedef struct packed {
        logic              emit;
        logic [DATA_W-1:0] out_byte;
        logic              byte_valid;
        logic              string_done;
        logic [ERR_W-1:0]  error_code;
    } jsu_result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_digit_t;

    function automatic hex_digit_t hex_value(input logic [DATA_W-1:0] b);
        hex_digit_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.val = 4'(b - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ----- rtl/jsu_decode.sv -----
// Next-state and result logic for one item of the JSON string unescape unit.
// Purely combinational; depends on jsu_pkg.
module jsu_decode (
    input  jsu_pkg::jsu_state_t        cur,
    input  logic [jsu_pkg::DATA_W-1:0] data_byte,
    input  logic                       end_of_data,
    output jsu_pkg::jsu_state_t        nxt,
    output jsu_pkg::jsu_result_t       res
);
    import jsu_pkg::*;

    hex_digit_t       hd;
    logic [ACC_W-1:0] acc_shift;

    assign hd        = hex_value(data_byte);
    assign acc_shift = {cur.acc[ACC_W-5:0], hd.val};

    always_comb begin
        nxt = cur;
        res = '0;
        case (cur.phase)
            PH_IDLE: begin
                if (end_of_data) begin
                    res.emit       = 1'b1;
                    res.error_code = ERR_NO_QUOTE;
                end else if (data_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
                    // skip blank
                end else if (data_byte == CH_QUOTE) begin
                    nxt.phase = PH_STR;
                end else begin
                    res.emit       = 1'b1;
                    res.error_code = ERR_NO_QUOTE;
                end
            end
            PH_STR: begin
                if (end_of_data) begin
                    nxt.phase      = PH_IDLE;
                    res.emit       = 1'b1;
                    res.error_code = ERR_UNT_STR;
                end else if (data_byte == CH_QUOTE) begin
                    nxt.phase       = PH_IDLE;
                    res.emit        = 1'b1;
                    res.string_done = 1'b1;
                end else if (data_byte == CH_BSL) begin
                    nxt.phase = PH_ESC;
                end else begin
                    res.emit       = 1'b1;
                    res.out_byte   = data_byte;
                    res.byte_valid = 1'b1;
                end
            end
            PH_ESC: begin
                if (end_of_data) begin
                    nxt.phase      = PH_IDLE;
                    res.emit       = 1'b1;
                    res.error_code = ERR_UNT_ESC;
                end else begin
                    nxt.phase      = PH_STR;
                    res.emit       = 1'b1;
                    res.byte_valid = 1'b1;
                    case (data_byte)
                        CH_QUOTE: res.out_byte = CH_QUOTE;
                        CH_BSL:   res.out_byte = CH_BSL;
                        CH_SLASH: res.out_byte = CH_SLASH;
                        CH_LC_B:  res.out_byte = CH_BS;
                        CH_LC_F:  res.out_byte = CH_FF;
                        CH_LC_N:  res.out_byte = CH_LF;
                        CH_LC_R:  res.out_byte = CH_CR;
                        CH_LC_T:  res.out_byte = CH_TAB;
                        CH_LC_U: begin
                            nxt.phase      = PH_HEX;
                            nxt.hex_cnt    = '0;
                            nxt.acc        = '0;
                            res.emit       = 1'b0;
                            res.byte_valid = 1'b0;
                        end
                        default: begin
                            nxt.phase      = PH_IDLE;
                            res.byte_valid = 1'b0;
                            res.error_code = ERR_BAD_ESC;
                        end
                    endcase
                end
            end
            PH_HEX: begin
                if (end_of_data || !hd.ok) begin
                    nxt.phase      = PH_IDLE;
                    nxt.hex_cnt    = '0;
                    nxt.acc        = '0;
                    res.emit       = 1'b1;
                    res.error_code = ERR_BAD_UNI;
                end else if (cur.hex_cnt == {HEXC_W{1'b1}}) begin
                    // fourth digit: emit ASCII code point or substitute
                    nxt.phase      = PH_STR;
                    nxt.hex_cnt    = '0;
                    nxt.acc        = '0;
                    res.emit       = 1'b1;
                    res.byte_valid = 1'b1;
                    res.out_byte   = (acc_shift < ASCII_LIMIT) ? acc_shift[DATA_W-1:0]
                                                               : CH_QMARK;
                end else begin
                    nxt.acc     = acc_shift;
                    nxt.hex_cnt = cur.hex_cnt + 1'b1;
                end
            end
            default: begin
                nxt.phase   = PH_IDLE;
                nxt.hex_cnt = '0;
                nxt.acc     = '0;
            end
        endcase
    end

endmodule

// ----- rtl/json_string_unescape_unit.sv -----
// Top level of the JSON string unescape unit: input register, decoder state,
// result register and handshakes. Depends on jsu_pkg and jsu_decode.
//
// Usage: each input item is one character byte (s_data_byte) or, with
// s_end_of_data set, an end-of-input mark. Items enter on s_valid/s_ready.
// Each item gives zero or one result on m_valid/m_ready: a decoded byte
// (m_byte_valid), a closing-quote mark (m_string_done) or an error code.
// Blanks before a string, the opening quote, a backslash and the first
// three hex digits of a \u escape give no result.
// Path: an accepted item sits in the input register while the decoder works,
// and its result loads into the result register once that register is free.
// Throughput: one item per cycle while m_ready does not hold back results;
// the state update lies between the input and result registers.
// Stall: while m_ready is low and a result waits, the input register holds
// and s_ready drops once it is full; no item is lost or repeated.
// Reset (aresetn low, synchronous): both registers empty, decoder idle,
// waiting for an opening quote.
module json_string_unescape_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [jsu_pkg::DATA_W-1:0] s_data_byte,
    input  logic                       s_end_of_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [jsu_pkg::DATA_W-1:0] m_out_byte,
    output logic                       m_byte_valid,
    output logic                       m_string_done,
    output logic [jsu_pkg::ERR_W-1:0]  m_error_code
);
    import jsu_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [DATA_W-1:0] in_byte_reg;
    logic              in_eod_reg;
    jsu_state_t        st_reg, st_next, st_dec;
    jsu_result_t       res_dec;
    logic              out_valid_reg, out_valid_next;
    jsu_result_t       out_reg;
    logic              out_free;
    logic              proc;

    jsu_decode u_decode (
        .cur         (st_reg),
        .data_byte   (in_byte_reg),
        .end_of_data (in_eod_reg),
        .nxt         (st_dec),
        .res         (res_dec)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign proc     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_comb begin
        in_valid_next  = in_valid_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (proc) begin
            st_next        = st_dec;
            out_valid_next = res_dec.emit;
            in_valid_next  = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg.phase  <= PH_IDLE;
            st_reg.hex_cnt <= '0;
            st_reg.acc    <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            st_reg        <= st_next;
        end
    end

    // payload registers: load on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_eod_reg  <= s_end_of_data;
        end
        if (proc && res_dec.emit) begin
            out_reg <= res_dec;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_out_byte    = out_reg.out_byte;
    assign m_byte_valid  = out_reg.byte_valid;
    assign m_string_done = out_reg.string_done;
    assign m_error_code  = out_reg.error_code;

`ifndef SYNTH
    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_string_done) |-> (!m_byte_valid && m_error_code == ERR_NONE))
        else $error("string_done result carries byte or error");

    a_err_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_code != ERR_NONE) |-> !m_byte_valid)
        else $error("error result carries a byte");

    a_err_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && res_dec.error_code != ERR_NONE) |=> (st_reg.phase == PH_IDLE))
        else $error("decoder not idle after error");

    a_hex_cnt_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.hex_cnt != '0) |-> (st_reg.phase == PH_HEX))
        else $error("hex digit count outside unicode escape");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(st_reg)))
        else $error("decoder advanced while result register blocked");
`endif

endmodule

// ----- tb/json_string_unescape_unit_tb.sv -----
// Testbench for json_string_unescape_unit: a directed stimulus table, then random
// JSON string literals (well-formed, broken and noise), checked against an in-bench
// decoder model or typed rows' results. Depends on jsu_pkg and the unit's RTL only.
module json_string_unescape_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYCLES = 11;
    localparam int ITEM_TARGET  = 1800;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;

    localparam logic [DATA_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [DATA_W-1:0] CH_NINE  = 8'h39;
    localparam logic [DATA_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [DATA_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [DATA_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [DATA_W-1:0] CH_LC_G  = 8'h67;
    localparam logic [DATA_W-1:0] CH_LC_Q  = 8'h71;
    localparam logic [DATA_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [DATA_W-1:0] CH_UC_F  = 8'h46;
    localparam logic [DATA_W-1:0] CH_SEVEN = 8'h37;
    localparam logic [DATA_W-1:0] CH_NINE2 = 8'h39;

    // Letters that may follow a backslash, apart from the unicode one
    localparam logic [8*DATA_W-1:0] ESC_LETTERS = {
        CH_QUOTE, CH_BSL, CH_SLASH, CH_LC_B, CH_LC_F, CH_LC_N, CH_LC_R, CH_LC_T
    };

    typedef struct packed {
        logic [DATA_W-1:0] out_byte;
        logic              byte_valid;
        logic              string_done;
        logic [ERR_W-1:0]  error_code;
    } char_result_t;

    typedef struct packed {
        logic [DATA_W-1:0] ch;
        logic              eod;
        bit                typed;
        char_result_t      res;
    } stim_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [DATA_W-1:0] s_data_byte = '0;
    logic              s_end_of_data = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [DATA_W-1:0] m_out_byte;
    logic              m_byte_valid;
    logic              m_string_done;
    logic [ERR_W-1:0]  m_error_code;

    // Decoder model state
    phase_t            dec_phase = PH_IDLE;
    logic [HEXC_W-1:0] dec_hex_cnt = '0;
    logic [ACC_W-1:0]  dec_code = '0;

    char_result_t pending_chars[$];
    stim_row_t    directed_rows[$];
    int           items_sent = 0;
    int           mismatches = 0;
    int           quiet_cycles = 0;
    int           src_idle = 0;
    int           dst_idle = 0;

    json_string_unescape_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_end_of_data (s_end_of_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_byte_valid  (m_byte_valid),
        .m_string_done (m_string_done),
        .m_error_code  (m_error_code)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Returns {is_hex, nibble}
    function automatic logic [4:0] nibble_of(input logic [DATA_W-1:0] ch);
        if (ch >= CH_ZERO && ch <= CH_NINE) return {1'b1, 4'(ch - CH_ZERO)};
        if (ch >= CH_LOW_A && ch <= CH_LC_F) return {1'b1, 4'(ch - CH_LOW_A + 8'd10)};
        if (ch >= CH_UC_A && ch <= CH_UC_F) return {1'b1, 4'(ch - CH_UC_A + 8'd10)};
        return 5'b0;
    endfunction

    function automatic bit is_escape_letter(input logic [DATA_W-1:0] ch);
        if (ch == CH_LC_U) return 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (ESC_LETTERS[8*i +: 8] == ch) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the decoder model by one item
    task automatic decode_char(input logic [DATA_W-1:0] ch, input logic eod,
                               output logic produced, output char_result_t res);
        logic [ERR_W-1:0] err;
        logic [4:0]       nib;
        logic [ACC_W-1:0] code;
        produced = 1'b0;
        res      = '0;
        err      = ERR_NONE;
        case (dec_phase)
            PH_IDLE: begin
                if (eod) begin
                    err = ERR_NO_QUOTE;
                end else if (ch == CH_QUOTE) begin
                    dec_phase = PH_STR;
                end else if (!(ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF)) begin
                    err = ERR_NO_QUOTE;
                end
            end
            PH_STR: begin
                if (eod) begin
                    err = ERR_UNT_STR;
                end else if (ch == CH_QUOTE) begin
                    dec_phase       = PH_IDLE;
                    produced        = 1'b1;
                    res.string_done = 1'b1;
                end else if (ch == CH_BSL) begin
                    dec_phase = PH_ESC;
                end else begin
                    produced       = 1'b1;
                    res.out_byte   = ch;
                    res.byte_valid = 1'b1;
                end
            end
            PH_ESC: begin
                if (eod) begin
                    err = ERR_UNT_ESC;
                end else begin
                    produced = 1'b1;
                    case (ch)
                        CH_QUOTE, CH_BSL, CH_SLASH: res.out_byte = ch;
                        CH_LC_B: res.out_byte = CH_BS;
                        CH_LC_F: res.out_byte = CH_FF;
                        CH_LC_N: res.out_byte = CH_LF;
                        CH_LC_R: res.out_byte = CH_CR;
                        CH_LC_T: res.out_byte = CH_TAB;
                        CH_LC_U: begin
                            produced    = 1'b0;
                            dec_phase   = PH_HEX;
                            dec_hex_cnt = '0;
                            dec_code    = '0;
                        end
                        default: begin
                            produced = 1'b0;
                            err      = ERR_BAD_ESC;
                        end
                    endcase
                    if (produced) begin
                        res.byte_valid = 1'b1;
                        dec_phase      = PH_STR;
                    end
                end
            end
            default: begin
                nib = nibble_of(ch);
                if (eod || !nib[4]) begin
                    err = ERR_BAD_UNI;
                end else begin
                    code = {dec_code[ACC_W-5:0], nib[3:0]};
                    if (dec_hex_cnt == 2'd3) begin
                        produced       = 1'b1;
                        res.byte_valid = 1'b1;
                        res.out_byte   = (code < ASCII_LIMIT) ? code[DATA_W-1:0] : CH_QMARK;
                        dec_phase      = PH_STR;
                        dec_hex_cnt    = '0;
                        dec_code       = '0;
                    end else begin
                        dec_hex_cnt = dec_hex_cnt + 1'b1;
                        dec_code    = code;
                    end
                end
            end
        endcase
        if (err != ERR_NONE) begin
            dec_phase      = PH_IDLE;
            dec_hex_cnt    = '0;
            dec_code       = '0;
            produced       = 1'b1;
            res            = '0;
            res.error_code = err;
        end
    endtask

    // Present one item and hold it until accepted; typed rows override the model
    task automatic send_char(input logic [DATA_W-1:0] ch, input logic eod,
                             input bit counts = 1'b1, input bit typed = 1'b0,
                             input char_result_t typed_res = '0);
        logic         produced;
        char_result_t res;
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        decode_char(ch, eod, produced, res);
        if (typed) pending_chars.push_back(typed_res);
        else if (produced) pending_chars.push_back(res);
        if (counts) items_sent++;
        s_valid       <= 1'b1;
        s_data_byte   <= ch;
        s_end_of_data <= eod;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [DATA_W-1:0] rand_hex_char();
        logic [3:0] n;
        n = 4'($urandom_range(15));
        if (n < 10) return CH_ZERO + n;
        return ($urandom_range(1) ? CH_UC_A : CH_LOW_A) + n - 8'd10;
    endfunction

    function automatic logic [DATA_W-1:0] rand_plain_char();
        logic [DATA_W-1:0] ch;
        do ch = 8'($urandom); while (ch == CH_QUOTE || ch == CH_BSL);
        return ch;
    endfunction

    task automatic send_unicode_prefix();
        send_char(CH_BSL, 1'b0);
        send_char(CH_LC_U, 1'b0);
    endtask

    task automatic send_element();
        int k;
        k = $urandom_range(3);
        if (k < 2) begin
            send_char(rand_plain_char(), 1'b0);
        end else if (k == 2) begin
            k = $urandom_range(7);
            send_char(CH_BSL, 1'b0);
            send_char(ESC_LETTERS[8*k +: 8], 1'b0);
        end else begin
            send_unicode_prefix();
            if ($urandom_range(1)) begin
                // bias toward code points near the ASCII limit
                send_char(CH_ZERO, 1'b0);
                send_char(CH_ZERO, 1'b0);
                send_char(CH_ZERO + 8'($urandom_range(8)), 1'b0);
            end else begin
                repeat (3) send_char(rand_hex_char(), 1'b0);
            end
            send_char(rand_hex_char(), 1'b0);
        end
    endtask

    // Cut a string short in one of the ways that ends in an error
    task automatic send_break();
        logic [DATA_W-1:0] ch;
        int k;
        k = $urandom_range(4);
        if (k == 0) begin
            send_char(8'($urandom), 1'b1);
            return;
        end
        if (k < 3) begin
            send_char(CH_BSL, 1'b0);
            if (k == 1) begin
                send_char(8'($urandom), 1'b1);
            end else begin
                do ch = 8'($urandom); while (is_escape_letter(ch));
                send_char(ch, 1'b0);
            end
            return;
        end
        send_unicode_prefix();
        repeat ($urandom_range(3)) send_char(rand_hex_char(), 1'b0);
        if (k == 3) begin
            send_char(8'($urandom), 1'b1);
        end else begin
            do ch = 8'($urandom); while (nibble_of(ch) != 5'b0);
            send_char(ch, 1'b0);
        end
    endtask

    task automatic send_random_string();
        logic [DATA_W-1:0] ch;
        int  n_elems;
        int  brk_at;
        bit  broken;
        // noise between strings
        if ($urandom_range(99) < 8) begin
            if ($urandom_range(1)) begin
                send_char(8'($urandom), 1'b1);
            end else begin
                do ch = 8'($urandom); while (ch == CH_QUOTE);
                send_char(ch, 1'b0);
            end
        end
        repeat ($urandom_range(2)) begin
            case ($urandom_range(3))
                0: ch = CH_SPACE;
                1: ch = CH_TAB;
                2: ch = CH_CR;
                default: ch = CH_LF;
            endcase
            send_char(ch, 1'b0, 1'b0);
        end
        send_char(CH_QUOTE, 1'b0);
        n_elems = $urandom_range(12);
        broken  = ($urandom_range(99) < 15);
        brk_at  = $urandom_range(n_elems);
        for (int i = 0; i <= n_elems; i++) begin
            if (broken && i == brk_at) begin
                send_break();
                return;
            end
            if (i == n_elems) send_char(CH_QUOTE, 1'b0);
            else send_element();
        end
    endtask

    task automatic add_row(input logic [DATA_W-1:0] ch, input logic eod,
                           input bit typed = 1'b0, input char_result_t res = '0);
        directed_rows.push_back({ch, eod, typed, res});
    endtask

    task automatic add_error_row(input logic [DATA_W-1:0] ch, input logic eod,
                                 input logic [ERR_W-1:0] code);
        add_row(ch, eod, 1'b1, {8'h00, 1'b0, 1'b0, code});
    endtask

    task automatic build_directed_rows();
        add_error_row(8'hFF, 1'b1, ERR_NO_QUOTE);
        add_row(CH_TAB, 1'b0);
        add_row(CH_CR, 1'b0);
        add_row(CH_LF, 1'b0);
        add_row(CH_SPACE, 1'b0);
        add_error_row(CH_UP_A, 1'b0, ERR_NO_QUOTE);
        add_row(CH_QUOTE, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(CH_BSL, 1'b0);
        add_row(CH_LC_U, 1'b0);
        add_row(CH_ZERO, 1'b0);
        add_row(CH_ZERO, 1'b0);
        add_row(CH_SEVEN, 1'b0);
        add_row(CH_UP_F, 1'b0);
        add_row(CH_BSL, 1'b0);
        add_row(CH_LC_U, 1'b0);
        add_row(CH_UC_F, 1'b0);
        add_row(CH_LC_F, 1'b0);
        add_row(CH_LOW_A, 1'b0);
        add_row(CH_NINE2, 1'b0);
        add_row(CH_QUOTE, 1'b0, 1'b1, {8'h00, 1'b0, 1'b1, ERR_NONE});
        add_row(CH_QUOTE, 1'b0);
        add_row(CH_BSL, 1'b0);
        add_error_row(CH_LC_Q, 1'b0, ERR_BAD_ESC);
        add_row(CH_QUOTE, 1'b0);
        add_row(CH_BSL, 1'b0);
        add_error_row(8'h00, 1'b1, ERR_UNT_ESC);
        add_row(CH_QUOTE, 1'b0);
        add_row(CH_BSL, 1'b0);
        add_row(CH_LC_U, 1'b0);
        add_error_row(CH_LC_G, 1'b0, ERR_BAD_UNI);
        add_row(CH_QUOTE, 1'b0);
        add_error_row(8'h55, 1'b1, ERR_UNT_STR);
    endtask

    initial begin
        src_idle = 33;
        dst_idle = 63;
        build_directed_rows();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[i]) begin
            send_char(directed_rows[i].ch, directed_rows[i].eod, 1'b1,
                      directed_rows[i].typed, directed_rows[i].res);
        end
        while (items_sent < ITEM_TARGET / 3) send_random_string();
        src_idle = 63;
        dst_idle = 33;
        while (items_sent < 2 * ITEM_TARGET / 3) send_random_string();
        src_idle = 0;
        dst_idle = 0;
        while (items_sent < ITEM_TARGET) send_random_string();
        s_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("json_string_unescape_unit_tb: clean");
        end else begin
            $display("json_string_unescape_unit_tb: errors");
        end
        $finish;
    end

    // Result side: random back-pressure, compare, watchdog
    always @(posedge aclk) begin
        char_result_t got;
        char_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= dst_idle);
            if (m_valid && m_ready) begin
                got = {m_out_byte, m_byte_valid, m_string_done, m_error_code};
                if (pending_chars.size() == 0) begin
                    if (mismatches < REPORT_MAX)
                        $display("unexpected item: byte %h valid %b done %b err %0d",
                                 got.out_byte, got.byte_valid, got.string_done,
                                 got.error_code);
                    mismatches++;
                end else begin
                    want = pending_chars.pop_front();
                    if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                        got.string_done !== want.string_done ||
                        got.error_code !== want.error_code) begin
                        if (mismatches < REPORT_MAX)
                            $display("mismatch: want byte %h valid %b done %b err %0d, got byte %h valid %b done %b err %0d",
                                     want.out_byte, want.byte_valid, want.string_done,
                                     want.error_code, got.out_byte, got.byte_valid,
                                     got.string_done, got.error_code);
                        mismatches++;
                    end
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: %0d items still outstanding", pending_chars.size());
                $display("json_string_unescape_unit_tb: errors");
                $finish;
            end
        end
    end

endmodule
